>>> rtl/core/vqa_pkg.sv
`timescale 1ns / 1ps

package vqa_pkg;

  // Command codes carried on the cmd field of a request.
  typedef enum logic [1:0] {
    CMD_WRITE_POS = 2'd0,
    CMD_ADD_TRI   = 2'd1,
    CMD_READ_QUAD = 2'd2
  } cmd_t;

  // Quadric layout: ten symmetric coefficients of 64 bits each.
  localparam int NUM_TERMS = 10;
  localparam int COEF_W    = 64;

  typedef logic [NUM_TERMS-1:0][COEF_W-1:0] quad_row_t;

  // Square root unit widths.
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int SQRT_STEPS = RAD_W / 2;

endpackage

>>> rtl/core/vertex_quadric_accumulator_core.sv
`timescale 1ns / 1ps

// Vertex quadric accumulator.
// One input channel (in_valid / in_stall) carries requests: write a vertex
// position, add a triangle, or read a vertex quadric. Only a read produces a
// result, on the output channel (out_valid / out_stall) with vertex_index and
// the ten Q36.28 coefficients q_aa .. q_dd.
// Position write: stored as the request is taken, with no stall. Quadric read:
// the row is read in S_QRD and loaded into the output register in S_QOUT; the
// block takes new requests while that result waits, and only a second read
// waits for the output register to free up. Triangle: no request is taken
// until it is done, one triangle at a time; a degenerate one ends in S_NORM.
// The work is the one-bit-a-cycle normalising shift, the iterative square
// root, three serial 15-bit divisions and the read-modify-write of three
// quadric memory rows. After reset the quadric memory is cleared one row a
// cycle, all MAX_VERTICES rows, while in_stall stays high. A stalled result
// holds its value.
module vertex_quadric_accumulator_core import vqa_pkg::*; #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [11:0]        index_a,
  input  logic [11:0]        index_b,
  input  logic [11:0]        index_c,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        vertex_index,
  output logic signed [63:0] q_aa,
  output logic signed [63:0] q_ab,
  output logic signed [63:0] q_ac,
  output logic signed [63:0] q_ad,
  output logic signed [63:0] q_bb,
  output logic signed [63:0] q_bc,
  output logic signed [63:0] q_bd,
  output logic signed [63:0] q_cc,
  output logic signed [63:0] q_cd,
  output logic signed [63:0] q_dd
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_POS_A, S_POS_B, S_POS_C, S_EDGE, S_CMUL, S_CROSS,
    S_NORM, S_SQ_MUL, S_SQ_SUM, S_SQ_START, S_SQ_WAIT, S_DIV_LOAD,
    S_DIV_STEP, S_DIV_END, S_DOT_MUL, S_DOT_SUM, S_TERM_MUL, S_RMW_RD,
    S_RMW_WR, S_QRD, S_QOUT
  } state_t;

  state_t state;

  // Memories.
  logic [71:0] pos_mem [MAX_VERTICES];
  quad_row_t   q_mem   [MAX_VERTICES];
  logic [71:0] pos_q;
  quad_row_t   q_rd;

  // Request bookkeeping.
  logic          in_accept;
  logic          a_ok, b_ok, c_ok;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] ia, ib, ic;
  logic          rd_ok;
  logic [11:0]   rd_index;

  // Triangle datapath registers.
  logic signed [23:0] p0 [3];
  logic signed [23:0] p1 [3];
  logic signed [24:0] e1 [3];
  logic signed [24:0] e2 [3];
  logic signed [49:0] prod [6];
  logic [50:0]        mag [3];
  logic               neg [3];
  logic [59:0]        sq_p [3];
  logic [61:0]        sq_sum;
  logic [ROOT_W-1:0]  len;
  logic [1:0]         kidx;
  logic [3:0]         step;
  logic [32:0]        rem;
  logic [14:0]        num_lo;
  logic [14:0]        quo;
  logic signed [15:0] nrm [3];
  logic signed [39:0] dprod [3];
  logic signed [30:0] dval;
  quad_row_t          terms;
  logic [1:0]         cidx;

  // Output register.
  quad_row_t out_row;

  // Combinational helpers.
  logic [50:0]        or_all;
  logic signed [50:0] cr [3];
  logic [44:0]        num;
  logic [32:0]        trial;
  logic signed [15:0] qs;
  logic signed [42:0] nd;
  logic [AW-1:0]      pos_addr;
  logic [AW-1:0]      corner;
  logic [AW-1:0]      q_addr;
  logic               q_rd_en;
  logic               q_we;
  quad_row_t          q_wdata;
  quad_row_t          sum_row;
  logic               sq_start;
  logic               sq_done;
  logic [ROOT_W-1:0]  sq_root;

  function automatic logic [COEF_W-1:0] sat_add(logic [COEF_W-1:0] a,
                                                logic [COEF_W-1:0] b);
    logic [COEF_W-1:0] s;
    s = a + b;
    if ((a[COEF_W-1] == b[COEF_W-1]) && (s[COEF_W-1] != a[COEF_W-1])) begin
      s = a[COEF_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end
    return s;
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && (state == S_IDLE);
  assign a_ok = ({20'd0, index_a} < 32'(MAX_VERTICES));
  assign b_ok = ({20'd0, index_b} < 32'(MAX_VERTICES));
  assign c_ok = ({20'd0, index_c} < 32'(MAX_VERTICES));

  // Cross product from the registered partial products.
  assign cr[0] = 51'(prod[0]) - 51'(prod[1]);
  assign cr[1] = 51'(prod[2]) - 51'(prod[3]);
  assign cr[2] = 51'(prod[4]) - 51'(prod[5]);
  assign or_all = mag[0] | mag[1] | mag[2];

  // Division numerator for the current component, and one restoring step.
  assign num   = {1'b0, mag[kidx][29:0], 14'd0} + 45'(len[ROOT_W-1:1]);
  assign trial = {rem[31:0], num_lo[14]};
  assign qs    = $signed({1'b0, quo});

  // Plane offset d = floor((2048 - n . p0) / 4096).
  assign nd = 43'sd2048 - ({{3{dprod[0][39]}}, dprod[0]}
                          + {{3{dprod[1][39]}}, dprod[1]}
                          + {{3{dprod[2][39]}}, dprod[2]});

  // Address selection for both memories.
  always_comb begin
    unique case (state)
      S_POS_A: pos_addr = ia;
      S_POS_B: pos_addr = ib;
      default: pos_addr = ic;
    endcase
    unique case (cidx)
      2'd0:    corner = ia;
      2'd1:    corner = ib;
      default: corner = ic;
    endcase
    q_rd_en = (state == S_RMW_RD) || ((state == S_QRD) && rd_ok);
    q_we    = (state == S_CLEAR) || (state == S_RMW_WR);
    if (state == S_CLEAR) begin
      q_addr = clr_addr;
    end else if (state == S_QRD) begin
      q_addr = ia;
    end else begin
      q_addr = corner;
    end
    for (int t = 0; t < NUM_TERMS; t++) begin
      sum_row[t] = sat_add(q_rd[t], terms[t]);
    end
    q_wdata = (state == S_CLEAR) ? '0 : sum_row;
  end

  // Position memory: written by requests, read three times per triangle.
  always_ff @(posedge clk) begin
    if (in_accept && (cmd_t'(cmd) == CMD_WRITE_POS) && a_ok) begin
      pos_mem[AW'(index_a)] <= {pos_x, pos_y, pos_z};
    end
    if ((state == S_POS_A) || (state == S_POS_B) || (state == S_POS_C)) begin
      pos_q <= pos_mem[pos_addr];
    end
  end

  // Quadric memory: one row per vertex.
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_addr] <= q_wdata;
    end
    if (q_rd_en) begin
      q_rd <= q_mem[q_addr];
    end
  end

  assign sq_start = (state == S_SQ_START);

  vqa_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ({2'b00, sq_sum}),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Sequencer with the datapath and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // In S_QOUT the result register is reloaded or held below.
      if (out_valid && !out_stall && (state != S_QOUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(MAX_VERTICES - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            ia       <= AW'(index_a);
            ib       <= AW'(index_b);
            ic       <= AW'(index_c);
            rd_ok    <= a_ok;
            rd_index <= index_a;
            unique case (cmd_t'(cmd))
              CMD_ADD_TRI: begin
                if (a_ok && b_ok && c_ok) begin
                  state <= S_POS_A;
                end
              end
              CMD_READ_QUAD: state <= S_QRD;
              default: ;
            endcase
          end
        end
        S_POS_A: state <= S_POS_B;
        S_POS_B: begin
          p0[0] <= pos_q[71:48];
          p0[1] <= pos_q[47:24];
          p0[2] <= pos_q[23:0];
          state <= S_POS_C;
        end
        S_POS_C: begin
          p1[0] <= pos_q[71:48];
          p1[1] <= pos_q[47:24];
          p1[2] <= pos_q[23:0];
          state <= S_EDGE;
        end
        S_EDGE: begin
          e1[0] <= 25'(p1[0]) - 25'(p0[0]);
          e1[1] <= 25'(p1[1]) - 25'(p0[1]);
          e1[2] <= 25'(p1[2]) - 25'(p0[2]);
          e2[0] <= 25'($signed(pos_q[71:48])) - 25'(p0[0]);
          e2[1] <= 25'($signed(pos_q[47:24])) - 25'(p0[1]);
          e2[2] <= 25'($signed(pos_q[23:0])) - 25'(p0[2]);
          state <= S_CMUL;
        end
        S_CMUL: begin
          prod[0] <= e1[1] * e2[2];
          prod[1] <= e1[2] * e2[1];
          prod[2] <= e1[2] * e2[0];
          prod[3] <= e1[0] * e2[2];
          prod[4] <= e1[0] * e2[1];
          prod[5] <= e1[1] * e2[0];
          state   <= S_CROSS;
        end
        S_CROSS: begin
          for (int k = 0; k < 3; k++) begin
            neg[k] <= cr[k][50];
            mag[k] <= cr[k][50] ? 51'(-cr[k]) : 51'(cr[k]);
          end
          state <= S_NORM;
        end
        // Shift all magnitudes one bit a cycle until the largest has 30 bits.
        S_NORM: begin
          if (or_all == '0) begin
            state <= S_IDLE;
          end else if (|or_all[50:30]) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] >> 1;
          end else if (!or_all[29]) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 1;
          end else begin
            state <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: begin
          for (int k = 0; k < 3; k++) sq_p[k] <= mag[k][29:0] * mag[k][29:0];
          state <= S_SQ_SUM;
        end
        S_SQ_SUM: begin
          sq_sum <= 62'(sq_p[0]) + 62'(sq_p[1]) + 62'(sq_p[2]);
          state  <= S_SQ_START;
        end
        S_SQ_START: state <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (sq_done) begin
            len   <= sq_root;
            kidx  <= 2'd0;
            state <= S_DIV_LOAD;
          end
        end
        S_DIV_LOAD: begin
          rem    <= 33'(num[44:15]);
          num_lo <= num[14:0];
          quo    <= '0;
          step   <= '0;
          state  <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          if (trial >= {1'b0, len}) begin
            rem <= trial - {1'b0, len};
            quo <= {quo[13:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[13:0], 1'b0};
          end
          num_lo <= num_lo << 1;
          step   <= step + 4'd1;
          if (step == 4'd14) begin
            state <= S_DIV_END;
          end
        end
        S_DIV_END: begin
          nrm[kidx] <= neg[kidx] ? -qs : qs;
          if (kidx == 2'd2) begin
            state <= S_DOT_MUL;
          end else begin
            kidx  <= kidx + 2'd1;
            state <= S_DIV_LOAD;
          end
        end
        S_DOT_MUL: begin
          for (int k = 0; k < 3; k++) dprod[k] <= nrm[k] * p0[k];
          state <= S_DOT_SUM;
        end
        S_DOT_SUM: begin
          dval  <= 31'(nd >>> 12);
          state <= S_TERM_MUL;
        end
        // Ten plane outer-product terms, each a single registered multiply.
        S_TERM_MUL: begin
          terms[0] <= 64'($signed(32'(nrm[0] * nrm[0])));
          terms[1] <= 64'($signed(32'(nrm[0] * nrm[1])));
          terms[2] <= 64'($signed(32'(nrm[0] * nrm[2])));
          terms[3] <= 64'($signed(47'(nrm[0] * dval)));
          terms[4] <= 64'($signed(32'(nrm[1] * nrm[1])));
          terms[5] <= 64'($signed(32'(nrm[1] * nrm[2])));
          terms[6] <= 64'($signed(47'(nrm[1] * dval)));
          terms[7] <= 64'($signed(32'(nrm[2] * nrm[2])));
          terms[8] <= 64'($signed(47'(nrm[2] * dval)));
          terms[9] <= 64'($signed(62'(dval * dval)));
          cidx     <= 2'd0;
          state    <= S_RMW_RD;
        end
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: begin
          if (cidx == 2'd2) begin
            state <= S_IDLE;
          end else begin
            cidx  <= cidx + 2'd1;
            state <= S_RMW_RD;
          end
        end
        S_QRD: state <= S_QOUT;
        S_QOUT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            vertex_index <= rd_index;
            out_row      <= rd_ok ? q_rd : '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign q_aa = out_row[0];
  assign q_ab = out_row[1];
  assign q_ac = out_row[2];
  assign q_ad = out_row[3];
  assign q_bb = out_row[4];
  assign q_bc = out_row[5];
  assign q_bd = out_row[6];
  assign q_cc = out_row[7];
  assign q_cd = out_row[8];
  assign q_dd = out_row[9];

endmodule

>>> rtl/core/vqa_isqrt.sv
`timescale 1ns / 1ps

// Integer square root, one result bit per cycle (floor of the root).
module vqa_isqrt import vqa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CW = $clog2(SQRT_STEPS);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [RAD_W-1:0] rem;
  logic [RAD_W-1:0] res;
  logic [RAD_W-1:0] bitv;
  logic [RAD_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  // Classic digit-by-digit root, starting from the top power of four.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(SQRT_STEPS - 1);
        rem  <= radicand;
        res  <= '0;
        bitv <= RAD_W'(1) << (RAD_W - 2);
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/vqa_checker.sv
`timescale 1ns / 1ps

// Port-level checks for the vertex quadric accumulator.
module vqa_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [11:0]        vertex_index,
  input logic signed [63:0] q_aa
);

  // The clearing pass after reset holds off requests.
  a_clear_stalls: assert property (@(posedge clk) rst |=> in_stall)
    else $error("request accepted during the clearing pass");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vertex_index) && $stable(q_aa))
    else $error("stalled result changed");

  // No result appears in the cycle right after a request is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A result is only loaded while the block is busy with a read.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result loaded while idle");

endmodule

bind vertex_quadric_accumulator_core vqa_checker u_vqa_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import vqa_pkg::*;

  // Code with no function in the block; it must be ignored.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NVERT = 4096;

  typedef longint coef_set_t[NUM_TERMS];

  typedef struct {
    logic [11:0] vertex;
    coef_set_t   coefs;
  } quad_read_t;

  // Scoreboard: mirrors the position and quadric stores and queues the
  // quadrics that read requests should return.
  class quadric_scoreboard;
    int         errors;
    int         vert_pos[NVERT][3];
    longint     vert_quad[NVERT][NUM_TERMS];
    quad_read_t quad_reads[$];
    string      names[NUM_TERMS] = '{"q_aa", "q_ab", "q_ac", "q_ad", "q_bb",
                                     "q_bc", "q_bd", "q_cc", "q_cd", "q_dd"};

    function new();
      errors = 0;
      foreach (vert_quad[v, t]) vert_quad[v][t] = 0;
      foreach (vert_pos[v, k]) vert_pos[v][k] = 0;
    endfunction

    function int pending();
      return quad_reads.size();
    endfunction

    function longint sat_add(longint a, longint b);
      longint r;
      r = a + b;
      if (a >= 0 && b >= 0 && r < 0) r = 64'sh7FFF_FFFF_FFFF_FFFF;
      if (a < 0 && b < 0 && r >= 0) r = 64'sh8000_0000_0000_0000;
      return r;
    endfunction

    // Plane of the triangle, then its outer product into each corner.
    function void add_face(int ia, int ib, int ic);
      longint e1[3], e2[3], cr[3], plane[4], dot, term;
      longint unsigned mag[3], m, sq, len, probe, rem, q;
      bit neg[3];
      int bl, idx, corner[3];
      for (int k = 0; k < 3; k++) begin
        e1[k] = longint'(vert_pos[ib][k]) - longint'(vert_pos[ia][k]);
        e2[k] = longint'(vert_pos[ic][k]) - longint'(vert_pos[ia][k]);
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      m = 0;
      for (int k = 0; k < 3; k++) begin
        neg[k] = cr[k] < 0;
        mag[k] = neg[k] ? -cr[k] : cr[k];
        if (mag[k] > m) m = mag[k];
      end
      // Degenerate face: no plane, nothing accumulated.
      if (m == 0) return;
      bl = 0;
      while (m != 0) begin
        bl++;
        m = m >> 1;
      end
      for (int k = 0; k < 3; k++)
        mag[k] = (bl > 30) ? (mag[k] >> (bl - 30)) : (mag[k] << (30 - bl));
      sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      // Integer square root, floor.
      len = 0;
      rem = sq;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
        if (rem >= len + probe) begin
          rem = rem - (len + probe);
          len = (len >> 1) + probe;
        end else begin
          len = len >> 1;
        end
        probe = probe >> 2;
      end
      if (len == 0) return;
      for (int k = 0; k < 3; k++) begin
        q = ((mag[k] << 14) + (len >> 1)) / len;
        plane[k] = neg[k] ? -longint'(q) : longint'(q);
      end
      dot = plane[0] * vert_pos[ia][0] + plane[1] * vert_pos[ia][1] +
            plane[2] * vert_pos[ia][2];
      plane[3] = (-dot + 2048) >>> 12;
      corner = '{ia, ib, ic};
      idx = 0;
      for (int i = 0; i < 4; i++)
        for (int j = i; j < 4; j++) begin
          term = plane[i] * plane[j];
          for (int k = 0; k < 3; k++)
            vert_quad[corner[k]][idx] = sat_add(vert_quad[corner[k]][idx], term);
          idx++;
        end
    endfunction

    function void note_request(logic [1:0] op, logic [11:0] a, logic [11:0] b,
                               logic [11:0] c, int x, int y, int z);
      quad_read_t rd;
      case (op)
        CMD_WRITE_POS: vert_pos[a] = '{x, y, z};
        CMD_ADD_TRI:   add_face(a, b, c);
        CMD_READ_QUAD: begin
          rd.vertex = a;
          foreach (rd.coefs[t]) rd.coefs[t] = vert_quad[a][t];
          quad_reads = {quad_reads, rd};
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [11:0] vi, coef_set_t got);
      quad_read_t exp_rd;
      if (quad_reads.size() == 0) begin
        $display("%0t: unexpected result for vertex %0d", $time, vi);
        errors++;
        return;
      end
      exp_rd = quad_reads.pop_front();
      if (vi !== exp_rd.vertex) begin
        $display("%0t: vertex_index expected %0d actual %0d", $time, exp_rd.vertex, vi);
        errors++;
      end
      foreach (got[t])
        if (got[t] !== exp_rd.coefs[t]) begin
          $display("%0t: vertex %0d %s expected %0d actual %0d", $time, exp_rd.vertex,
                   names[t], exp_rd.coefs[t], got[t]);
          errors++;
        end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         cmd;
  logic [11:0]        index_a;
  logic [11:0]        index_b;
  logic [11:0]        index_c;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic               out_valid;
  logic               out_stall;
  logic [11:0]        vertex_index;
  logic signed [63:0] q_aa, q_ab, q_ac, q_ad, q_bb, q_bc, q_bd, q_cc, q_cd, q_dd;

  quadric_scoreboard sb = new();
  bit                calm = 0;
  bit                long_hold = 0;
  bit                written[NVERT];
  int                written_list[$];

  vertex_quadric_accumulator_core dut (.*);

  // Clock.
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        out_stall <= 0;
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result(vertex_index, '{q_aa, q_ab, q_ac, q_ad, q_bb,
                                      q_bc, q_bd, q_cc, q_cd, q_dd});

  // Offer one request, with an occasional idle burst first; returns at the
  // falling edge after it is taken.
  task automatic send(logic [1:0] op, logic [11:0] a, logic [11:0] b, logic [11:0] c,
                      logic [23:0] x, logic [23:0] y, logic [23:0] z);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    cmd <= op;
    index_a <= a;
    index_b <= b;
    index_c <= c;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, a, b, c, $signed(x), $signed(y), $signed(z));
    @(negedge clk);
  endtask

  task automatic put_vertex(logic [11:0] a, logic [23:0] x, logic [23:0] y,
                            logic [23:0] z);
    send(CMD_WRITE_POS, a, 12'($urandom), 12'($urandom), x, y, z);
    if (!written[a]) written_list = {written_list, int'(a)};
    written[a] = 1;
  endtask

  task automatic face(logic [11:0] a, logic [11:0] b, logic [11:0] c);
    send(CMD_ADD_TRI, a, b, c, 24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic read_quad(logic [11:0] a);
    send(CMD_READ_QUAD, a, 12'($urandom), 12'($urandom), 24'($urandom), 24'($urandom),
         24'($urandom));
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 8191)) - 4096);
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(0, 524287)) - 262144);
    endcase
  endfunction

  function automatic logic [11:0] pick_written();
    return 12'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  // Main stimulus.
  initial begin
    int sel;
    logic [11:0] a, b, c;
    rst = 1;
    in_valid = 0;
    cmd = CMD_WRITE_POS;
    index_a = 0;
    index_b = 0;
    index_c = 0;
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: extreme corners, collinear and repeated-corner faces, a
    // tiny face, reads of untouched vertices and the unused code.
    put_vertex(0, 24'h800000, 24'h800000, 24'h800000);
    put_vertex(4095, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    put_vertex(1, 24'h7FFFFF, 24'h800000, 24'h000000);
    put_vertex(2, 24'h000000, 24'h7FFFFF, 24'h800000);
    put_vertex(5, 0, 0, 0);
    put_vertex(3, 1, 0, 0);
    put_vertex(4, 2, 0, 0);
    put_vertex(6, 0, 1, 0);
    read_quad(0);
    face(0, 1, 2);
    face(4095, 1, 2);
    face(5, 3, 4);
    face(3, 3, 5);
    face(5, 3, 6);
    face(0, 4095, 1);
    send(CMD_UNUSED, 12'hFFF, 12'hFFF, 12'hFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    read_quad(0);
    read_quad(1);
    read_quad(3);
    read_quad(6);
    read_quad(4095);
    read_quad(7);

    // Receiver holds off while reads keep coming, so the block backs up.
    long_hold = 1;
    for (int i = 0; i < 12; i++) read_quad(pick_written());
    in_valid <= 0;
    // Sender waits until every outstanding read has returned.
    while (sb.pending() != 0) @(negedge clk);

    // Random part: mostly valid meshes on a small working set.
    for (int i = 0; i < 1850; i++) begin
      calm = i > 1650;
      sel = $urandom_range(0, 99);
      if (sel < 28 || written_list.size() < 3) begin
        a = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 63)) : 12'($urandom);
        put_vertex(a, rand_coord(), rand_coord(), rand_coord());
      end else if (sel < 64) begin
        a = pick_written();
        b = pick_written();
        c = pick_written();
        if ($urandom_range(0, 9) == 0) c = b;
        face(a, b, c);
      end else if (sel < 95) begin
        read_quad(($urandom_range(0, 4) != 0) ? pick_written() : 12'($urandom));
      end else begin
        send(CMD_UNUSED, 12'($urandom), 12'($urandom), 12'($urandom), 24'($urandom),
             24'($urandom), 24'($urandom));
      end
    end
    in_valid <= 0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
